### src/mtf_pkg.sv
// Package with the shared constants, types and state codes of the move-to-front encoder.
`default_nettype none

package mtf_pkg;

  localparam int ALPHABET_DEF = 256;
  localparam int SYMBOL_W     = 9;
  localparam int POSITION_W   = 9;

  typedef enum logic {
    MTF_IDLE,
    MTF_SWEEP
  } mtf_state_e;

  typedef struct packed {
    logic adv;
    logic clear;
  } mtf_ctrl_t;

endpackage

`default_nettype wire

### src/mtf_cell.sv
// One list entry of the move-to-front chain, with its share of the moving wavefront.
`default_nettype none

module mtf_cell #(
  parameter int EntW       = 9,
  parameter int ResetValue = 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire mtf_pkg::mtf_ctrl_t ctrl_i,
  input  wire logic [EntW-1:0]   sym_i,
  input  wire logic              tok_i,
  input  wire logic [EntW-1:0]   carry_i,
  output logic                   tok_o,
  output logic [EntW-1:0]        carry_o,
  output logic                   hit_o
);

  logic [EntW-1:0] entry_q, entry_d;
  logic [EntW-1:0] carry_q, carry_d;
  logic            tok_q, tok_d;

  assign hit_o   = tok_q && (entry_q == sym_i);
  assign tok_o   = tok_q && !hit_o;
  assign carry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    carry_d = carry_q;
    tok_d   = tok_q;
    if (ctrl_i.clear) begin
      entry_d = EntW'(ResetValue);
      tok_d   = 1'b0;
    end else if (ctrl_i.adv) begin
      tok_d   = tok_i;
      carry_d = carry_i;
      if (tok_q) begin
        entry_d = carry_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= EntW'(ResetValue);
      tok_q   <= 1'b0;
    end else begin
      entry_q <= entry_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
  end

endmodule

`default_nettype wire

### src/move_to_front_encoder.sv
// Top level of the move-to-front encoder: control, output register and the chain of cells.
// A symbol found at 1-based position p gives position p as its result once the wavefront reaches it.
// A symbol outside 1 to ALPHABET gives position 0 in the cycle after acceptance.
// The next transaction is taken once the encoder is back in idle and the output is not stalled.
// The wavefront moves one cell of the chain per cycle while the output is not stalled.
// Reset puts the list in natural order in every cell at once; there is no clearing pass.
`default_nettype none

module move_to_front_encoder #(
  parameter int ALPHABET = mtf_pkg::ALPHABET_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [mtf_pkg::SYMBOL_W-1:0]   symbol_i,
  input  wire logic                           last_item_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [mtf_pkg::POSITION_W-1:0]      position_o,
  output logic                                last_out_o
);

  localparam int EntW = $clog2(ALPHABET + 1);
  localparam int CntW = $clog2(ALPHABET + 1);

  mtf_pkg::mtf_state_e state_q, state_d;
  mtf_pkg::mtf_ctrl_t  ctrl;

  logic [EntW-1:0]                  sym_q, sym_d;
  logic                             last_q, last_d;
  logic [CntW-1:0]                  cnt_q, cnt_d;
  logic                             out_valid_q, out_valid_d;
  logic [mtf_pkg::POSITION_W-1:0]   pos_q, pos_d;
  logic                             last_out_q, last_out_d;

  logic                             accept;
  logic                             in_range;
  logic                             start;
  logic                             hit_any;
  logic                             adv;
  logic                             clear;

  logic [ALPHABET-1:0]              hit;
  logic [ALPHABET-1:0]              tok_in;
  logic [ALPHABET-1:0]              tok_out;
  logic [EntW-1:0]                  carry_in  [ALPHABET];
  logic [EntW-1:0]                  carry_out [ALPHABET];

  assign adv        = !(out_valid_q && !out_ready_i);
  assign ctrl       = {adv, clear};
  assign in_ready_o = (state_q == mtf_pkg::MTF_IDLE) && adv;
  assign accept     = in_valid_i && in_ready_o;
  assign in_range   = (symbol_i != '0) && (32'(symbol_i) <= 32'(ALPHABET));
  assign start      = accept && in_range;
  assign hit_any    = |hit;

  assign tok_in[0]   = start;
  assign carry_in[0] = EntW'(symbol_i);

  for (genvar k = 0; k < ALPHABET; k++) begin : g_cell
    if (k > 0) begin : g_link
      assign tok_in[k]   = tok_out[k-1];
      assign carry_in[k] = carry_out[k-1];
    end

    mtf_cell #(
      .EntW       (EntW),
      .ResetValue (k + 1)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .sym_i   (sym_q),
      .tok_i   (tok_in[k]),
      .carry_i (carry_in[k]),
      .tok_o   (tok_out[k]),
      .carry_o (carry_out[k]),
      .hit_o   (hit[k])
    );
  end

  always_comb begin
    state_d     = state_q;
    sym_d       = sym_q;
    last_d      = last_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    pos_d       = pos_q;
    last_out_d  = last_out_q;
    clear       = 1'b0;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      mtf_pkg::MTF_IDLE: begin
        if (accept) begin
          sym_d  = EntW'(symbol_i);
          last_d = last_item_i;
          if (in_range) begin
            cnt_d   = CntW'(1);
            state_d = mtf_pkg::MTF_SWEEP;
          end else begin
            out_valid_d = 1'b1;
            pos_d       = '0;
            last_out_d  = last_item_i;
            clear       = last_item_i;
          end
        end
      end
      mtf_pkg::MTF_SWEEP: begin
        if (adv) begin
          if (hit_any) begin
            out_valid_d = 1'b1;
            pos_d       = mtf_pkg::POSITION_W'(cnt_q);
            last_out_d  = last_q;
            clear       = last_q;
            state_d     = mtf_pkg::MTF_IDLE;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = mtf_pkg::MTF_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mtf_pkg::MTF_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q      <= sym_d;
    last_q     <= last_d;
    cnt_q      <= cnt_d;
    pos_q      <= pos_d;
    last_out_q <= last_out_d;
  end

  assign out_valid_o = out_valid_q;
  assign position_o  = pos_q;
  assign last_out_o  = last_out_q;

endmodule

`default_nettype wire

### src/mtf_checker.sv
// Port-level assertions for the move-to-front encoder and the bind that attaches them.
`default_nettype none

module mtf_checker #(
  parameter int ALPHABET = mtf_pkg::ALPHABET_DEF
) (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         in_valid_i,
  input wire logic                         in_ready_o,
  input wire logic [mtf_pkg::SYMBOL_W-1:0] symbol_i,
  input wire logic                         last_item_i,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire logic [mtf_pkg::POSITION_W-1:0] position_o,
  input wire logic                         last_out_o
);

  logic in_acc;
  logic sym_ok;

  assign in_acc = in_valid_i && in_ready_o;
  assign sym_ok = (symbol_i != '0) && (32'(symbol_i) <= 32'(ALPHABET));

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(position_o) && $stable(last_out_o))
    else $error("A waiting result transaction changed before it was taken.");

  a_bad_symbol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !sym_ok |=>
      out_valid_o && (position_o == '0) && (last_out_o == $past(last_item_i)))
    else $error("An out-of-range symbol did not give position zero in the next cycle.");

  a_sweep_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && sym_ok |=> !in_ready_o && !out_valid_o)
    else $error("The encoder was not busy in the cycle after a valid symbol.");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (ALPHABET < 512) |-> 32'(position_o) <= 32'(ALPHABET))
    else $error("A result position lies beyond the alphabet.");

endmodule

bind move_to_front_encoder mtf_checker #(.ALPHABET(ALPHABET)) u_mtf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .symbol_i    (symbol_i),
  .last_item_i (last_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .position_o  (position_o),
  .last_out_o  (last_out_o)
);

`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for the move-to-front encoder, with its own list model and handshakes.
`timescale 1ns / 100ps

module tb;

  localparam int ALPHABET = mtf_pkg::ALPHABET_DEF;
  localparam int SYM_W    = mtf_pkg::SYMBOL_W;
  localparam int POS_W    = mtf_pkg::POSITION_W;

  typedef struct packed {
    logic [POS_W-1:0] position;
    logic             last_out;
  } mtf_result_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  logic [SYM_W-1:0] symbol_i    = '0;
  logic             last_item_i = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  logic [POS_W-1:0] position_o;
  logic             last_out_o;

  logic [12:0]  symbol_order [ALPHABET];
  mtf_result_t  awaited_positions [$];
  int           mismatch_count = 0;
  int           sender_idle_pct = 0;
  int           receiver_stall_pct = 0;

  move_to_front_encoder #(
    .ALPHABET(ALPHABET)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .symbol_i   (symbol_i),
    .last_item_i(last_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .position_o (position_o),
    .last_out_o (last_out_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic void restore_natural_order();
    for (int i = 0; i < ALPHABET; i++) begin
      symbol_order[i] = 13'(i + 1);
    end
  endfunction

  function automatic mtf_result_t encode_symbol(input logic [SYM_W-1:0] sym, input logic last);
    mtf_result_t res;
    logic        found;
    int          hit;
    found = 1'b0;
    hit = 0;
    for (int i = 0; i < ALPHABET; i++) begin
      if (!found && symbol_order[i] == 13'(sym)) begin
        found = 1'b1;
        hit = i;
      end
    end
    if (found) begin
      for (int k = hit; k > 0; k--) begin
        symbol_order[k] = symbol_order[k - 1];
      end
      symbol_order[0] = 13'(sym);
      res.position = POS_W'(hit + 1);
    end else begin
      res.position = '0;
    end
    res.last_out = last;
    if (last) begin
      restore_natural_order();
    end
    return res;
  endfunction

  function automatic void note_mismatch(input string what, input int want, input int got);
    if (mismatch_count < 10) begin
      $display("Mismatch on %s: expected %0d, actual %0d", what, want, got);
    end
    mismatch_count++;
  endfunction

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Each accepted input transaction is predicted before the output transaction of this edge is checked.
  always @(posedge clk_i) begin : result_check
    mtf_result_t want;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        awaited_positions.push_back(encode_symbol(symbol_i, last_item_i));
      end
      if (out_valid_o && out_ready_i) begin
        if (awaited_positions.size() == 0) begin
          note_mismatch("unexpected result, position", -1, position_o);
        end else begin
          want = awaited_positions.pop_front();
          if (position_o !== want.position) begin
            note_mismatch("position", want.position, position_o);
          end
          if (last_out_o !== want.last_out) begin
            note_mismatch("last_out", want.last_out, last_out_o);
          end
        end
      end
    end
  end

  task automatic send_symbol(input logic [SYM_W-1:0] sym, input logic last);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    symbol_i    <= sym;
    last_item_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_until_drained();
    do @(posedge clk_i); while (awaited_positions.size() != 0);
  endtask

  task automatic test_directed_cases();
    send_symbol(9'd1, 1'b0);
    send_symbol(9'd256, 1'b0);
    send_symbol(9'd256, 1'b0);
    send_symbol(9'd1, 1'b0);
    send_symbol(9'd128, 1'b0);
    send_symbol(9'd170, 1'b0);
    send_symbol(9'd255, 1'b0);
    send_symbol(9'd0, 1'b0);
    send_symbol(9'd511, 1'b0);
    send_symbol(9'd257, 1'b0);
    send_symbol(9'd341, 1'b0);
    send_symbol(9'd2, 1'b1);
    send_symbol(9'd256, 1'b0);
    send_symbol(9'd1, 1'b0);
    send_symbol(9'd0, 1'b1);
    send_symbol(9'd256, 1'b0);
    send_symbol(9'd85, 1'b0);
    send_symbol(9'd85, 1'b0);
    send_symbol(9'd3, 1'b1);
    send_symbol(9'd256, 1'b1);
  endtask

  // Sequences mostly draw from a narrow window so that symbols recur near the front of the list.
  task automatic test_sequences(input int n_items);
    int               sent;
    int               len;
    int               span;
    int               base;
    logic [SYM_W-1:0] sym;
    logic             last;
    sent = 0;
    while (sent < n_items) begin
      len  = $urandom_range(1, 48);
      span = ($urandom_range(3) == 0) ? ALPHABET : $urandom_range(2, 12);
      base = $urandom_range(1, ALPHABET - span + 1);
      for (int i = 0; i < len && sent < n_items; i++) begin
        if ($urandom_range(19) == 0) begin
          sym = $urandom_range(1) ? '0 : SYM_W'($urandom_range(ALPHABET + 1, 511));
        end else begin
          sym = SYM_W'(base + $urandom_range(span - 1));
        end
        if (i == len - 1) begin
          last = ($urandom_range(9) != 0);
        end else begin
          last = ($urandom_range(63) == 0);
        end
        send_symbol(sym, last);
        sent++;
      end
    end
  endtask

  task automatic test_drain_pause();
    test_sequences(10);
    in_valid_i <= 1'b0;
    wait_until_drained();
    test_sequences(10);
  endtask

  initial begin
    restore_natural_order();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();

    test_sequences(205);

    sender_idle_pct = 78;
    test_sequences(205);

    sender_idle_pct = 0;
    receiver_stall_pct = 78;
    test_sequences(205);

    sender_idle_pct = 21;
    receiver_stall_pct = 21;
    test_sequences(205);
    test_drain_pause();

    in_valid_i <= 1'b0;
    wait_until_drained();
    repeat (300) @(posedge clk_i);
    mismatch_count += awaited_positions.size();
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### move_to_front_encoder.f
src/mtf_pkg.sv
src/mtf_cell.sv
src/move_to_front_encoder.sv
src/mtf_checker.sv
tb/sv/tb.sv
